[sv/gcsp_pkg.sv]
`default_nettype none
package gcsp_pkg;

  localparam int CAP   = 64;
  localparam int IDX_W = (CAP > 2) ? $clog2(CAP) : 1;
  localparam int CNT_W = $clog2(CAP + 1);

  localparam int MODE_W  = 2;
  localparam int CP_W    = 21;
  localparam int SCORE_W = 8;
  localparam int SLOT_W  = 6;
  localparam int FSEL_W  = 2;
  localparam int FILL_W  = 7;

  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PINNED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_AGE    = 2'd3;

  localparam logic [CP_W-1:0]    SPACE_CP     = 21'h20;
  localparam logic [SCORE_W-1:0] SCORE_CAP    = 8'd254;
  localparam logic [SCORE_W-1:0] SCORE_PINNED = 8'd255;
  localparam logic [SCORE_W-1:0] SCORE_INSERT = 8'd5;

  localparam logic [FSEL_W-1:0] FSEL_BASIC = 2'd0;
  localparam logic [FSEL_W-1:0] FSEL_PUA   = 2'd1;
  localparam logic [FSEL_W-1:0] FSEL_UPPER = 2'd2;
  localparam logic [FSEL_W-1:0] FSEL_NONE  = 2'd3;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 4'd1;
  localparam logic [OP_W-1:0] OP_READ     = 4'd2;
  localparam logic [OP_W-1:0] OP_NEXT     = 4'd3;
  localparam logic [OP_W-1:0] OP_INS      = 4'd4;
  localparam logic [OP_W-1:0] OP_RAISE    = 4'd5;
  localparam logic [OP_W-1:0] OP_SHIFT    = 4'd6;
  localparam logic [OP_W-1:0] OP_FIN      = 4'd7;
  localparam logic [OP_W-1:0] OP_AGE      = 4'd8;
  localparam logic [OP_W-1:0] OP_RES_HIT  = 4'd9;
  localparam logic [OP_W-1:0] OP_RES_MISS = 4'd10;
  localparam logic [OP_W-1:0] OP_RES_DROP = 4'd11;
  localparam logic [OP_W-1:0] OP_PUSH     = 4'd12;

  typedef struct packed {
    logic [CP_W-1:0]    tag;
    logic [SCORE_W-1:0] score;
    logic               wide;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              count_zero;
    logic              full;
    logic              last;
    logic              idx_zero;
    logic              match;
    logic              capped;
    logic              lower;
    logic              out_free;
  } status_t;

  function automatic logic [FSEL_W-1:0] font_range(input logic [CP_W-1:0] cp);
    logic [FSEL_W-1:0] f;
    if (cp <= 21'h0d8ff || (cp >= 21'h0f900 && cp <= 21'h0ffff)) begin
      f = FSEL_BASIC;
    end else if (cp >= 21'h0e000 && cp <= 21'h0f8ff) begin
      f = FSEL_PUA;
    end else if ((cp >= 21'h10000 && cp <= 21'h1ffff) ||
                 (cp >= 21'he0000 && cp <= 21'heffff)) begin
      f = FSEL_UPPER;
    end else if (cp >= 21'hf0000 && cp <= 21'hffffd) begin
      f = FSEL_PUA;
    end else begin
      f = FSEL_NONE;
    end
    return f;
  endfunction

endpackage
`default_nettype wire

[sv/gcsp_if.sv]
`default_nettype none
interface gcsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [gcsp_pkg::MODE_W-1:0] mode;
  logic [gcsp_pkg::CP_W-1:0]   codepoint;
  logic                        glyph_wide;
  modport source (output valid, mode, codepoint, glyph_wide, input ready);
  modport sink (input valid, mode, codepoint, glyph_wide, output ready);
endinterface

interface gcsp_out_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic [gcsp_pkg::SLOT_W-1:0] slot;
  logic                        wide;
  logic [gcsp_pkg::FSEL_W-1:0] font_select;
  logic                        dropped;
  logic [gcsp_pkg::FILL_W-1:0] fill;
  modport source (output valid, hit, slot, wide, font_select, dropped, fill, input ready);
  modport sink (input valid, hit, slot, wide, font_select, dropped, fill, output ready);
endinterface
`default_nettype wire

[sv/glyph_cache_score_policy.sv]
// channel | dir | beat payload
// in_ch   | in  | mode, codepoint, glyph_wide
// out_ch  | out | hit, slot, wide, font_select, dropped, fill
//
// One item at a time; each visited entry uses the single tag/score RAM
// read port (read, then check). Lookup: dispatch, search, bubble, finish.
// Insert and aging walk up to fill entries the same way.
// Synchronous active-low reset empties the store at once; no clearing pass.
// A result waits in the output register while the next beat is worked on;
// that beat holds in its last state until the register frees.
`default_nettype none
module glyph_cache_score_policy (
  input  wire logic   clk,
  input  wire logic   rst_n,
  gcsp_in_if.sink     in_ch,
  gcsp_out_if.source  out_ch
);
  import gcsp_pkg::*;

  cmd_t    cmd;
  status_t st;

  gcsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  gcsp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_ch.mode),
    .in_codepoint  (in_ch.codepoint),
    .in_glyph_wide (in_ch.glyph_wide),
    .cmd           (cmd),
    .st            (st),
    .out_ch        (out_ch)
  );

endmodule
`default_nettype wire

[sv/gcsp_ram.sv]
`default_nettype none
module gcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH > 2 ? DEPTH : 2)-1:0] raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/gcsp_ctrl.sv]
`default_nettype none
module gcsp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire gcsp_pkg::status_t st,
  output gcsp_pkg::cmd_t         cmd
);
  import gcsp_pkg::*;

  localparam int ST_W = 4;
  localparam logic [ST_W-1:0] S_IDLE  = 4'd0;
  localparam logic [ST_W-1:0] S_DISP  = 4'd1;
  localparam logic [ST_W-1:0] S_SRD   = 4'd2;
  localparam logic [ST_W-1:0] S_SCHK  = 4'd3;
  localparam logic [ST_W-1:0] S_BRD   = 4'd4;
  localparam logic [ST_W-1:0] S_BCHK  = 4'd5;
  localparam logic [ST_W-1:0] S_BFIN  = 4'd6;
  localparam logic [ST_W-1:0] S_ARD   = 4'd7;
  localparam logic [ST_W-1:0] S_ACHK  = 4'd8;
  localparam logic [ST_W-1:0] S_DONE  = 4'd9;

  logic [ST_W-1:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (st.mode)
          MODE_LOOKUP: begin
            if (st.count_zero) begin
              cmd.op    = OP_RES_MISS;
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SRD;
            end
          end
          MODE_AGE: begin
            state_nxt = st.count_zero ? S_DONE : S_ARD;
          end
          default: begin
            if (st.mode == MODE_PINNED && !st.count_zero) begin
              state_nxt = S_SRD;
            end else if (st.full) begin
              cmd.op    = OP_RES_DROP;
              state_nxt = S_DONE;
            end else begin
              cmd.op    = OP_INS;
              state_nxt = st.count_zero ? S_BFIN : S_BRD;
            end
          end
        endcase
      end
      S_SRD: begin
        cmd.op    = OP_READ;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (st.match) begin
          if (st.mode == MODE_LOOKUP && !st.capped) begin
            cmd.op    = OP_RAISE;
            state_nxt = st.idx_zero ? S_BFIN : S_BRD;
          end else begin
            cmd.op    = OP_RES_HIT;
            state_nxt = S_DONE;
          end
        end else if (!st.last) begin
          cmd.op    = OP_NEXT;
          state_nxt = S_SRD;
        end else if (st.mode == MODE_LOOKUP) begin
          cmd.op    = OP_RES_MISS;
          state_nxt = S_DONE;
        end else if (st.full) begin
          cmd.op    = OP_RES_DROP;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_INS;
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        cmd.op    = OP_READ;
        state_nxt = S_BCHK;
      end
      S_BCHK: begin
        if (st.lower) begin
          cmd.op    = OP_SHIFT;
          state_nxt = st.idx_zero ? S_BFIN : S_BRD;
        end else begin
          state_nxt = S_BFIN;
        end
      end
      S_BFIN: begin
        cmd.op    = OP_FIN;
        state_nxt = S_DONE;
      end
      S_ARD: begin
        cmd.op    = OP_READ;
        state_nxt = S_ACHK;
      end
      S_ACHK: begin
        cmd.op    = OP_AGE;
        state_nxt = st.last ? S_DONE : S_ARD;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[sv/gcsp_dp.sv]
`default_nettype none
module gcsp_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [gcsp_pkg::MODE_W-1:0] in_mode,
  input  wire logic [gcsp_pkg::CP_W-1:0]   in_codepoint,
  input  wire logic                        in_glyph_wide,
  input  wire gcsp_pkg::cmd_t              cmd,
  output gcsp_pkg::status_t                st,
  gcsp_out_if.source                       out_ch
);
  import gcsp_pkg::*;

  logic [MODE_W-1:0]  mode_r;
  logic [CP_W-1:0]    cp_r;
  logic               gw_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   hole_r;
  logic [CNT_W-1:0]   kept_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  entry_t             held_r;
  logic               res_hit_r;
  logic [IDX_W-1:0]   res_slot_r;
  logic               res_wide_r;
  logic [FSEL_W-1:0]  res_fsel_r;
  logic               res_drop_r;
  logic               out_valid_r, out_valid_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  entry_t             rdata;
  logic [ENTRY_W-1:0] rdata_raw;
  logic [SCORE_W-1:0] aged;
  logic               keep;

  gcsp_ram #(.WIDTH(ENTRY_W), .DEPTH(CAP)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.op == OP_READ),
    .raddr (idx_r),
    .rdata (rdata_raw)
  );

  assign rdata = entry_t'(rdata_raw);

  always_comb begin
    if (rdata.score == SCORE_PINNED) begin
      aged = SCORE_PINNED;
    end else if (rdata.score != '0) begin
      aged = rdata.score - 8'd1;
    end else begin
      aged = '0;
    end
  end
  assign keep = (aged != '0);

  always_comb begin
    we    = 1'b0;
    waddr = idx_r;
    wdata = rdata;
    case (cmd.op)
      OP_SHIFT: begin
        we    = 1'b1;
        waddr = hole_r;
      end
      OP_FIN: begin
        we    = 1'b1;
        waddr = hole_r;
        wdata = held_r;
      end
      OP_AGE: begin
        we          = keep;
        waddr       = kept_r[IDX_W-1:0];
        wdata.score = aged;
      end
      default: begin
      end
    endcase
  end

  assign st.mode       = mode_r;
  assign st.count_zero = (count_r == '0);
  assign st.full       = (count_r >= CNT_W'(CAP));
  assign st.last       = ({1'b0, idx_r} == (count_r - CNT_W'(1)));
  assign st.idx_zero   = (idx_r == '0);
  assign st.match      = (rdata.tag == cp_r);
  assign st.capped     = (rdata.score >= SCORE_CAP);
  assign st.lower      = (rdata.score < held_r.score);
  assign st.out_free   = !out_valid_r || out_ch.ready;

  always_comb begin
    count_nxt = count_r;
    if (cmd.op == OP_INS) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.op == OP_AGE && st.last) begin
      count_nxt = keep ? kept_r + CNT_W'(1) : kept_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.op == OP_PUSH) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r     <= in_mode;
        cp_r       <= (in_codepoint == '0) ? SPACE_CP : in_codepoint;
        gw_r       <= in_glyph_wide;
        idx_r      <= '0;
        kept_r     <= '0;
        res_hit_r  <= 1'b0;
        res_slot_r <= '0;
        res_wide_r <= 1'b0;
        res_fsel_r <= FSEL_NONE;
        res_drop_r <= 1'b0;
      end
      OP_NEXT: begin
        idx_r <= idx_r + IDX_W'(1);
      end
      OP_INS: begin
        held_r.tag   <= cp_r;
        held_r.score <= (mode_r == MODE_PINNED) ? SCORE_PINNED : SCORE_INSERT;
        held_r.wide  <= gw_r;
        hole_r       <= count_r[IDX_W-1:0];
        idx_r        <= IDX_W'(count_r - CNT_W'(1));
      end
      OP_RAISE: begin
        held_r.tag   <= rdata.tag;
        held_r.score <= rdata.score + 8'd1;
        held_r.wide  <= rdata.wide;
        hole_r       <= idx_r;
        idx_r        <= idx_r - IDX_W'(1);
      end
      OP_SHIFT: begin
        hole_r <= idx_r;
        idx_r  <= idx_r - IDX_W'(1);
      end
      OP_FIN: begin
        res_hit_r  <= (mode_r == MODE_LOOKUP);
        res_slot_r <= hole_r;
        res_wide_r <= held_r.wide;
      end
      OP_AGE: begin
        idx_r <= idx_r + IDX_W'(1);
        if (keep) begin
          kept_r <= kept_r + CNT_W'(1);
        end
      end
      OP_RES_HIT: begin
        res_hit_r  <= 1'b1;
        res_slot_r <= idx_r;
        res_wide_r <= rdata.wide;
        res_drop_r <= (mode_r == MODE_PINNED);
      end
      OP_RES_MISS: begin
        res_fsel_r <= font_range(cp_r);
      end
      OP_RES_DROP: begin
        res_drop_r <= 1'b1;
      end
      OP_PUSH: begin
        out_ch.hit         <= res_hit_r;
        out_ch.slot        <= SLOT_W'(res_slot_r);
        out_ch.wide        <= res_wide_r;
        out_ch.font_select <= res_fsel_r;
        out_ch.dropped     <= res_drop_r;
        out_ch.fill        <= FILL_W'(count_r);
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid = out_valid_r;

endmodule
`default_nettype wire

[sv/gcsp_checker.sv]
`default_nettype none
module gcsp_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        out_hit,
  input wire logic [gcsp_pkg::FSEL_W-1:0] out_font_select,
  input wire logic                        out_dropped,
  input wire logic [gcsp_pkg::FILL_W-1:0] out_fill
);
  import gcsp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_fill) && $stable(out_hit))
    else $error("stalled result changed");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill <= FILL_W'(CAP))
    else $error("fill above capacity");

  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_font_select != FSEL_NONE |-> !out_hit && !out_dropped)
    else $error("font range reported with hit or drop");

endmodule

bind glyph_cache_score_policy gcsp_checker u_gcsp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_hit         (out_ch.hit),
  .out_font_select (out_ch.font_select),
  .out_dropped     (out_ch.dropped),
  .out_fill        (out_ch.fill)
);
`default_nettype wire

[tb/sv/glyph_cache_score_policy_test.sv]
module glyph_cache_score_policy_test;
  import gcsp_pkg::*;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              wide;
    logic [FSEL_W-1:0] font_select;
    logic              dropped;
    logic [FILL_W-1:0] fill;
  } glyph_res_t;

  class glyph_scoreboard;
    logic [CP_W-1:0]    tags[CAP];
    logic [SCORE_W-1:0] scores[CAP];
    logic               widths[CAP];
    int                 count;
    glyph_res_t         pending[$];
    int                 errors;

    function void swap_at(int a, int b);
      logic [CP_W-1:0] t;
      logic [SCORE_W-1:0] s;
      logic w;
      t = tags[a]; s = scores[a]; w = widths[a];
      tags[a] = tags[b]; scores[a] = scores[b]; widths[a] = widths[b];
      tags[b] = t; scores[b] = s; widths[b] = w;
    endfunction

    function int bump(int idx);
      if (scores[idx] >= SCORE_CAP) return idx;
      scores[idx] = scores[idx] + 8'd1;
      while (idx > 0 && scores[idx-1] < scores[idx]) begin
        swap_at(idx - 1, idx);
        idx--;
      end
      return idx;
    endfunction

    function int locate(logic [CP_W-1:0] cp);
      for (int i = 0; i < count; i++) if (tags[i] == cp) return i;
      return -1;
    endfunction

    function logic [FSEL_W-1:0] range_of(logic [CP_W-1:0] cp);
      if (cp <= 21'h0d8ff || (cp >= 21'h0f900 && cp <= 21'h0ffff)) return FSEL_BASIC;
      if (cp >= 21'h0e000 && cp <= 21'h0f8ff) return FSEL_PUA;
      if ((cp >= 21'h10000 && cp <= 21'h1ffff) || (cp >= 21'he0000 && cp <= 21'heffff))
        return FSEL_UPPER;
      if (cp >= 21'hf0000 && cp <= 21'hffffd) return FSEL_PUA;
      return FSEL_NONE;
    endfunction

    function void note_beat(logic [MODE_W-1:0] mode, logic [CP_W-1:0] cp, logic gw);
      glyph_res_t r;
      int pos, kept;
      r = '0;
      r.font_select = FSEL_NONE;
      if (cp == 0) cp = SPACE_CP;
      if (mode == MODE_LOOKUP) begin
        pos = locate(cp);
        if (pos >= 0) begin
          pos = bump(pos);
          r.hit = 1; r.slot = SLOT_W'(pos); r.wide = widths[pos];
        end else r.font_select = range_of(cp);
      end else if (mode == MODE_INSERT || mode == MODE_PINNED) begin
        pos = (mode == MODE_PINNED) ? locate(cp) : -1;
        if (pos >= 0) begin
          r.dropped = 1; r.hit = 1; r.slot = SLOT_W'(pos); r.wide = widths[pos];
        end else if (count >= CAP) begin
          r.dropped = 1;
        end else begin
          pos = count;
          tags[pos] = cp; scores[pos] = '0; widths[pos] = gw;
          count++;
          for (int k = 0; k < 5; k++) pos = bump(pos);
          if (mode == MODE_PINNED) begin
            scores[pos] = SCORE_PINNED;
            while (pos > 0 && scores[pos-1] < SCORE_PINNED) begin
              swap_at(pos - 1, pos);
              pos--;
            end
          end
          r.slot = SLOT_W'(pos); r.wide = gw;
        end
      end else begin
        kept = 0;
        for (int i = 0; i < count; i++) begin
          if (scores[i] != SCORE_PINNED) begin
            if (scores[i] > 0) scores[i] = scores[i] - 8'd1;
            if (scores[i] == 0) continue;
          end
          tags[kept] = tags[i]; scores[kept] = scores[i]; widths[kept] = widths[i];
          kept++;
        end
        count = kept;
      end
      r.fill = FILL_W'(count);
      pending.push_back(r);
    endfunction

    function void check_beat(glyph_res_t got);
      glyph_res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  gcsp_in_if in_ch();
  gcsp_out_if out_ch();
  glyph_scoreboard sb = new();
  logic [CP_W-1:0] pool[16];

  glyph_cache_score_policy uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.mode = MODE_LOOKUP;
    in_ch.codepoint = '0;
    in_ch.glyph_wide = 0;
    out_ch.ready = 0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task send_beat(logic [MODE_W-1:0] mode, logic [CP_W-1:0] cp, logic gw);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.mode <= mode;
    in_ch.codepoint <= cp;
    in_ch.glyph_wide <= gw;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(mode, cp, gw);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_beat({out_ch.hit, out_ch.slot, out_ch.wide, out_ch.font_select,
                     out_ch.dropped, out_ch.fill});
  end

  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = (($urandom_range(0, 3) == 0) ? pick_gap() : 0);
      out_ch.ready <= (n == 0);
      @(posedge clk);
      if (n != 0) begin
        repeat (n - 1) @(posedge clk);
        out_ch.ready <= 1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [CP_W-1:0] cp;
    logic [MODE_W-1:0] mode;
    int sel;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_beat(MODE_LOOKUP, 21'h0, 0);
    send_beat(MODE_AGE, 21'h0, 0);
    send_beat(MODE_INSERT, 21'h0, 1);
    send_beat(MODE_LOOKUP, 21'h20, 0);
    send_beat(MODE_PINNED, 21'h1fffff, 1);
    send_beat(MODE_PINNED, 21'h1fffff, 0);
    send_beat(MODE_INSERT, 21'h41, 0);
    send_beat(MODE_INSERT, 21'h41, 1);
    send_beat(MODE_LOOKUP, 21'h41, 0);
    send_beat(MODE_LOOKUP, 21'h0d8ff, 0);
    send_beat(MODE_LOOKUP, 21'h0d900, 0);
    send_beat(MODE_LOOKUP, 21'h0e000, 0);
    send_beat(MODE_LOOKUP, 21'h0f900, 0);
    send_beat(MODE_LOOKUP, 21'h10000, 0);
    send_beat(MODE_LOOKUP, 21'h20000, 0);
    send_beat(MODE_LOOKUP, 21'he0000, 0);
    send_beat(MODE_LOOKUP, 21'hffffd, 0);
    send_beat(MODE_LOOKUP, 21'hffffe, 0);
    send_beat(MODE_LOOKUP, 21'h10ffff, 0);
    for (int i = 0; i < 6; i++) send_beat(MODE_AGE, 21'h0, 0);
    foreach (pool[i]) pool[i] = CP_W'($urandom_range(0, 21'h1fffff));
    pool[0] = 0;
    for (int i = 0; i < 600; i++) begin
      sel = $urandom_range(0, 99);
      if ((i / 150) % 2 == 1) begin
        // fill phase: drive the store to full
        mode = (sel < 70) ? MODE_INSERT : (sel < 80) ? MODE_PINNED : MODE_LOOKUP;
      end else begin
        mode = (sel < 50) ? MODE_LOOKUP : (sel < 70) ? MODE_INSERT :
               (sel < 78) ? MODE_PINNED : MODE_AGE;
      end
      cp = ($urandom_range(0, 3) != 0) ? pool[$urandom_range(0, 15)]
                                       : CP_W'($urandom_range(0, 21'h1fffff));
      send_beat(mode, cp, 1'($urandom_range(0, 1)));
    end
    in_ch.valid <= 0;
    for (int k = 0; k < 20000 && sb.pending.size() != 0; k++) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end
endmodule
